### src/multi_pattern_byte_scanner_core_defines.svh
// ----------------------------------------------------------------------------
// Multi-pattern byte scanner assertion macros
// Shared concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MULTI_PATTERN_BYTE_SCANNER_CORE_DEFINES_SVH
`define MULTI_PATTERN_BYTE_SCANNER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define MPBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MPBS_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`else
`define MPBS_ASSERT(lbl, prop, msg)
`define MPBS_ASSERT_NEXT(lbl, cond, prop, msg)
`endif

`endif

### src/mpbs_pkg.sv
// ----------------------------------------------------------------------------
// Multi-pattern byte scanner package
// Payload types, opcodes, table sizes and the case folding function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mpbs_pkg;

  localparam int MAX_NODES    = 1024;
  localparam int MAX_PATTERNS = 64;
  localparam int NODE_W       = 10;
  localparam int BYTE_W       = 8;
  localparam int PAT_W        = 64;
  localparam int TRANS_AW     = NODE_W + BYTE_W;

  localparam logic [PAT_W-1:0] PAT_MASK = {PAT_W{1'b1}} >> (PAT_W - MAX_PATTERNS);

  localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_BIT     = 8'h20;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int CNT_W      = 3;

  typedef enum logic [1:0] {
    OP_LOAD_TRANS = 2'd0,
    OP_LOAD_MASK  = 2'd1,
    OP_SCAN       = 2'd2,
    OP_RESERVED   = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [NODE_W-1:0] node_index;
    logic [BYTE_W-1:0] data_byte;
    logic [NODE_W-1:0] next_node;
    logic [PAT_W-1:0]  pattern_mask;
    logic              end_of_text;
  } in_t;

  typedef struct packed {
    logic [PAT_W-1:0] hit_mask;
    logic [PAT_W-1:0] seen_mask;
    logic             any_match;
    logic             text_done;
  } out_t;

  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
    fold_case = ((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) ? (b | CASE_BIT) : b;
  endfunction

endpackage

### src/mpbs_ram.sv
// ----------------------------------------------------------------------------
// Multi-pattern byte scanner RAM
// Simple dual-port synchronous RAM, read-first, with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpbs_ram #(
  parameter int AW = 10,
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [(2**AW)-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/mpbs_out_fifo.sv
// ----------------------------------------------------------------------------
// Multi-pattern byte scanner result queue
// Small register queue that holds results until the output transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpbs_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mpbs_pkg::out_t      push_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mpbs_pkg::out_t      out_data
);

  mpbs_pkg::out_t                   entry_r [mpbs_pkg::FIFO_DEPTH-1:0];
  logic [mpbs_pkg::FIFO_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [mpbs_pkg::FIFO_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [mpbs_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic                             pop;

  assign out_valid = (count_r != '0);
  assign out_data  = entry_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + mpbs_pkg::CNT_W'(push) - mpbs_pkg::CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### src/multi_pattern_byte_scanner_core.sv
// Each result passes the s1 and s2 registers and the result queue before output.
// Throughput: one item per cycle while in_ready is high; the next node address
// is the transition RAM output, so consecutive scan bytes chain with no bubble.
// Reset (synchronous): current node returns to root and the seen bitmap clears.
// The transition and match RAMs are not cleared and must be loaded first.
// ----------------------------------------------------------------------------
// Multi-pattern byte scanner core
// Steps a preloaded automaton one byte per cycle while in_ready is high and tracks matched patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multi_pattern_byte_scanner_core_defines.svh"

module multi_pattern_byte_scanner_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  mpbs_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mpbs_pkg::out_t out_data
);

  logic                              in_xfer, out_xfer;
  logic [mpbs_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [mpbs_pkg::NODE_W-1:0]       node_r, node_nxt;
  logic [mpbs_pkg::NODE_W-1:0]       cur_node;
  logic [mpbs_pkg::NODE_W-1:0]       step_node;
  logic [mpbs_pkg::PAT_W-1:0]        seen_r, seen_nxt;
  logic                              s1_valid_r, s1_scan_r, s1_eot_r;
  logic                              s2_valid_r, s2_scan_r, s2_eot_r;
  logic                              in_scan;
  logic                              trans_we, match_we;
  logic [mpbs_pkg::TRANS_AW-1:0]     trans_waddr, trans_raddr;
  logic [mpbs_pkg::NODE_W-1:0]       trans_rdata;
  logic [mpbs_pkg::PAT_W-1:0]        match_rdata;
  logic [mpbs_pkg::PAT_W-1:0]        hit;
  logic [mpbs_pkg::PAT_W-1:0]        seen_out;
  logic                              done;
  mpbs_pkg::out_t                    result;

  assign in_ready = (cnt_r < mpbs_pkg::CNT_W'(mpbs_pkg::FIFO_DEPTH));
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign in_scan  = (in_data.opcode == mpbs_pkg::OP_SCAN);

  assign step_node = (32'(trans_rdata) < mpbs_pkg::MAX_NODES) ? trans_rdata : '0;

  always_comb begin
    if (s1_valid_r && s1_scan_r) begin
      cur_node = s1_eot_r ? '0 : step_node;
    end else begin
      cur_node = node_r;
    end
  end

  assign node_nxt = cur_node;

  assign trans_we = in_xfer && (in_data.opcode == mpbs_pkg::OP_LOAD_TRANS) &&
                    (32'(in_data.node_index) < mpbs_pkg::MAX_NODES) &&
                    (32'(in_data.next_node) < mpbs_pkg::MAX_NODES);
  assign trans_waddr = {in_data.node_index, in_data.data_byte};
  assign trans_raddr = {cur_node, mpbs_pkg::fold_case(in_data.data_byte)};

  assign match_we = in_xfer && (in_data.opcode == mpbs_pkg::OP_LOAD_MASK) &&
                    (32'(in_data.node_index) < mpbs_pkg::MAX_NODES);

  mpbs_ram #(
    .AW (mpbs_pkg::TRANS_AW),
    .DW (mpbs_pkg::NODE_W)
  ) u_trans_ram (
    .clk   (clk),
    .we    (trans_we),
    .waddr (trans_waddr),
    .wdata (in_data.next_node),
    .raddr (trans_raddr),
    .rdata (trans_rdata)
  );

  mpbs_ram #(
    .AW (mpbs_pkg::NODE_W),
    .DW (mpbs_pkg::PAT_W)
  ) u_match_ram (
    .clk   (clk),
    .we    (match_we),
    .waddr (in_data.node_index),
    .wdata (in_data.pattern_mask & mpbs_pkg::PAT_MASK),
    .raddr (step_node),
    .rdata (match_rdata)
  );

  always_comb begin
    hit      = (s2_valid_r && s2_scan_r) ? match_rdata : '0;
    seen_out = seen_r | hit;
    done     = s2_valid_r && s2_scan_r && s2_eot_r;
    seen_nxt = seen_r;
    if (s2_valid_r) begin
      seen_nxt = done ? '0 : seen_out;
    end
    result.hit_mask  = hit;
    result.seen_mask = seen_out;
    result.any_match = |seen_out;
    result.text_done = done;
    cnt_nxt = cnt_r + mpbs_pkg::CNT_W'(in_xfer) - mpbs_pkg::CNT_W'(out_xfer);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      node_r     <= '0;
      seen_r     <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      node_r     <= node_nxt;
      seen_r     <= seen_nxt;
      s1_valid_r <= in_xfer;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_scan_r <= in_scan;
    s1_eot_r  <= in_data.end_of_text;
    s2_scan_r <= s1_scan_r;
    s2_eot_r  <= s1_eot_r;
  end

  mpbs_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s2_valid_r),
    .push_data (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `MPBS_ASSERT(a_out_needs_credit, !out_valid || (cnt_r != '0), "Result offered with no item outstanding.")
  `MPBS_ASSERT_NEXT(a_eot_node_root, s1_valid_r && s1_scan_r && s1_eot_r, node_r == '0, "Node not at root after end of text.")
  `MPBS_ASSERT_NEXT(a_eot_seen_clear, done, seen_r == '0, "Seen bitmap not cleared after end of text.")
  `MPBS_ASSERT(a_stage_credit, !s2_valid_r || (cnt_r != '0), "Item in flight without an outstanding count.")

endmodule

### tb/multi_pattern_byte_scanner_core_test.sv
// ----------------------------------------------------------------------------
// Multi-pattern byte scanner core testbench
// Loads small automata through the input channel, scans text bytes through
// them and checks every result against a scoreboard model of the scanner or a
// fixed row result, with random idle cycles on input and result channel in most phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_pattern_byte_scanner_core_test;
  import mpbs_pkg::*;

  localparam int NUM_ROWS = 24;
  localparam int PHASE_ITEMS = 300;
  localparam int SETTLE_CYCLES = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TRANS_DEPTH = MAX_NODES * 256;

  localparam out_t ZERO_RES = '0;
  localparam out_t FULL_RES = '{hit_mask: '1, seen_mask: '1, any_match: 1'b1,
                                text_done: 1'b0};
  localparam out_t DONE_RES = '{hit_mask: '0, seen_mask: '0, any_match: 1'b0,
                                text_done: 1'b1};

  typedef struct packed {
    in_t  item;
    logic fixed;
    out_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  logic row_fixed = 1'b0;
  out_t row_res = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int quiet_cycles = 0;

  logic [NODE_W-1:0] walk_node = '0;
  logic [PAT_W-1:0] seen_bits = '0;
  logic [NODE_W-1:0] next_of [0:TRANS_DEPTH-1];
  bit next_known [0:TRANS_DEPTH-1];
  logic [PAT_W-1:0] ends_at [0:MAX_NODES-1];

  out_t awaited[$];
  row_t script [NUM_ROWS];

  multi_pattern_byte_scanner_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] b);
    if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
      return b | CASE_BIT;
    end
    return b;
  endfunction

  function automatic in_t mk(opcode_t op, logic [NODE_W-1:0] node,
                             logic [BYTE_W-1:0] b, logic [NODE_W-1:0] nxt,
                             logic [PAT_W-1:0] m, logic eot);
    mk = '{opcode: op, node_index: node, data_byte: b, next_node: nxt,
           pattern_mask: m, end_of_text: eot};
  endfunction

  // Steps the scoreboard copy of the automaton by one transfer.
  function automatic out_t scan_step(input in_t it);
    out_t res;
    logic [NODE_W-1:0] nxt;
    res = '0;
    case (opcode_t'(it.opcode))
      OP_LOAD_TRANS: begin
        next_of[{it.node_index, it.data_byte}] = it.next_node;
        next_known[{it.node_index, it.data_byte}] = 1'b1;
      end
      OP_LOAD_MASK: begin
        ends_at[it.node_index] = it.pattern_mask & PAT_MASK;
      end
      OP_SCAN: begin
        nxt = next_of[{walk_node, to_lower(it.data_byte)}];
        res.hit_mask = ends_at[nxt];
        seen_bits = seen_bits | res.hit_mask;
        walk_node = nxt;
        res.text_done = it.end_of_text;
      end
      default: begin
      end
    endcase
    res.seen_mask = seen_bits;
    res.any_match = (seen_bits != '0);
    if (res.text_done) begin
      walk_node = '0;
      seen_bits = '0;
    end
    return res;
  endfunction

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : monitor
    out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        want = scan_step(in_data);
        if (row_fixed) begin
          want = row_res;
        end
        awaited.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          $error("Result transfer with no pending item: %h", out_data);
          errors++;
        end else begin
          want = awaited.pop_front();
          if (out_data.hit_mask !== want.hit_mask) begin
            $error("hit_mask: expected %h, actual %h", want.hit_mask, out_data.hit_mask);
            errors++;
          end
          if (out_data.seen_mask !== want.seen_mask) begin
            $error("seen_mask: expected %h, actual %h", want.seen_mask,
                   out_data.seen_mask);
            errors++;
          end
          if (out_data.any_match !== want.any_match) begin
            $error("any_match: expected %b, actual %b", want.any_match,
                   out_data.any_match);
            errors++;
          end
          if (out_data.text_done !== want.text_done) begin
            $error("text_done: expected %b, actual %b", want.text_done,
                   out_data.text_done);
            errors++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic push_item(input in_t item, input logic fixed, input out_t res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    row_fixed <= fixed;
    row_res <= res;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  function automatic in_t noise_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(in_t)-1:0];
  endfunction

  function automatic logic [PAT_W-1:0] random_pattern();
    logic [PAT_W-1:0] m;
    case ($urandom_range(0, 3))
      0: m = '0;
      1: m = {{(PAT_W-1){1'b0}}, 1'b1} << $urandom_range(0, PAT_W - 1);
      default: m = {$urandom, $urandom};
    endcase
    return m;
  endfunction

  // Loads a fresh small automaton, then streams text through it with some
  // table rewrites and unused opcodes mixed in.
  task automatic run_phase(input int send_pct, input int recv_pct);
    logic [NODE_W-1:0] states[$];
    logic [BYTE_W-1:0] letters[$];
    logic [BYTE_W-1:0] b;
    in_t it;
    int made;
    int pick;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    states.push_back('0);
    repeat ($urandom_range(2, 5)) begin
      states.push_back(NODE_W'($urandom_range(1, MAX_NODES - 1)));
    end
    repeat ($urandom_range(3, 6)) begin
      if ($urandom_range(0, 1)) begin
        letters.push_back(BYTE_W'($urandom_range(8'h61, 8'h7A)));
      end else begin
        letters.push_back(to_lower(BYTE_W'($urandom_range(0, 255))));
      end
    end
    made = 0;
    foreach (states[s]) begin
      foreach (letters[l]) begin
        it = noise_item();
        it.opcode = OP_LOAD_TRANS;
        it.node_index = states[s];
        it.data_byte = letters[l];
        it.next_node = states[$urandom_range(0, states.size() - 1)];
        push_item(it, 1'b0, ZERO_RES);
        made++;
      end
    end
    foreach (states[s]) begin
      it = noise_item();
      it.opcode = OP_LOAD_MASK;
      it.node_index = states[s];
      it.pattern_mask = random_pattern();
      push_item(it, 1'b0, ZERO_RES);
      made++;
    end
    while (made < PHASE_ITEMS) begin
      it = noise_item();
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        if ($urandom_range(0, 3) != 0) begin
          b = letters[$urandom_range(0, letters.size() - 1)];
          if (b >= 8'h61 && b <= 8'h7A && $urandom_range(0, 1)) begin
            b = b & ~CASE_BIT;
          end
        end else begin
          b = BYTE_W'($urandom_range(0, 255));
        end
        while (!next_known[{walk_node, to_lower(b)}]) begin
          b = BYTE_W'($urandom_range(0, 255));
        end
        it.opcode = OP_SCAN;
        it.data_byte = b;
        it.end_of_text = ($urandom_range(0, 9) == 0);
        made++;
      end else if (pick < 88) begin
        it.opcode = OP_LOAD_MASK;
        if ($urandom_range(0, 1)) begin
          it.node_index = states[$urandom_range(0, states.size() - 1)];
        end
        it.pattern_mask = random_pattern();
        made++;
      end else if (pick < 95) begin
        it.opcode = OP_LOAD_TRANS;
        if ($urandom_range(0, 1)) begin
          it.node_index = states[$urandom_range(0, states.size() - 1)];
          it.data_byte = letters[$urandom_range(0, letters.size() - 1)];
        end else begin
          it.data_byte = to_lower(it.data_byte);
        end
        it.next_node = states[$urandom_range(0, states.size() - 1)];
        made++;
      end else begin
        it.opcode = OP_RESERVED;
      end
      push_item(it, 1'b0, ZERO_RES);
    end
  endtask

  initial begin : stimulus
    script = '{
      {mk(OP_LOAD_MASK, 10'd0, 8'h00, 10'd0, 64'h0, 1'b0), 1'b1, ZERO_RES},
      {mk(OP_LOAD_MASK, 10'd1023, 8'h00, 10'd0, '1, 1'b1), 1'b1, ZERO_RES},
      {mk(OP_LOAD_MASK, 10'd1, 8'h00, 10'd0, 64'h1, 1'b0), 1'b1, ZERO_RES},
      {mk(OP_RESERVED, 10'd1023, 8'hFF, 10'd1023, '1, 1'b1), 1'b1, ZERO_RES},
      {mk(OP_LOAD_TRANS, 10'd0, 8'h61, 10'd1, 64'h0, 1'b0), 1'b1, ZERO_RES},
      {mk(OP_LOAD_TRANS, 10'd0, 8'h00, 10'd0, 64'h0, 1'b0), 1'b1, ZERO_RES},
      {mk(OP_LOAD_TRANS, 10'd0, 8'h40, 10'd0, 64'h0, 1'b0), 1'b1, ZERO_RES},
      {mk(OP_LOAD_TRANS, 10'd0, 8'h5B, 10'd1, 64'h0, 1'b0), 1'b1, ZERO_RES},
      {mk(OP_LOAD_TRANS, 10'd1, 8'h7A, 10'd1023, 64'h0, 1'b0), 1'b1, ZERO_RES},
      {mk(OP_LOAD_TRANS, 10'd1, 8'h00, 10'd0, 64'h0, 1'b0), 1'b1, ZERO_RES},
      {mk(OP_LOAD_TRANS, 10'd1023, 8'hFF, 10'd1023, 64'h0, 1'b0), 1'b1, ZERO_RES},
      {mk(OP_LOAD_TRANS, 10'd1023, 8'h00, 10'd0, 64'h0, 1'b0), 1'b1, ZERO_RES},
      {mk(OP_LOAD_TRANS, 10'd0, 8'h41, 10'd1023, 64'h0, 1'b0), 1'b1, ZERO_RES},
      {mk(OP_SCAN, 10'd0, 8'h41, 10'd0, 64'h0, 1'b0), 1'b0, ZERO_RES},
      {mk(OP_SCAN, 10'd0, 8'h5A, 10'd0, 64'h0, 1'b0), 1'b1, FULL_RES},
      {mk(OP_SCAN, 10'd0, 8'hFF, 10'd0, 64'h0, 1'b0), 1'b1, FULL_RES},
      {mk(OP_LOAD_MASK, 10'd1, 8'h00, 10'd0, 64'h2, 1'b1), 1'b0, ZERO_RES},
      {mk(OP_SCAN, 10'd0, 8'h00, 10'd0, 64'h0, 1'b1), 1'b0, ZERO_RES},
      {mk(OP_SCAN, 10'd0, 8'h00, 10'd0, 64'h0, 1'b1), 1'b1, DONE_RES},
      {mk(OP_SCAN, 10'd0, 8'h40, 10'd0, 64'h0, 1'b0), 1'b0, ZERO_RES},
      {mk(OP_SCAN, 10'd0, 8'h5B, 10'd0, 64'h0, 1'b0), 1'b0, ZERO_RES},
      {mk(OP_SCAN, 10'd0, 8'h7A, 10'd0, 64'h0, 1'b0), 1'b1, FULL_RES},
      {mk(OP_SCAN, 10'd0, 8'h00, 10'd0, 64'h0, 1'b1), 1'b0, ZERO_RES},
      {mk(OP_RESERVED, 10'd0, 8'h00, 10'd0, 64'h0, 1'b0), 1'b1, ZERO_RES}
    };
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 6;
    recv_idle_pct = 59;
    for (int i = 0; i < NUM_ROWS; i++) begin
      push_item(script[i].item, script[i].fixed, script[i].res);
    end
    run_phase(6, 59);
    run_phase(59, 6);
    run_phase(0, 0);
    in_valid <= 1'b0;
    row_fixed <= 1'b0;
    while (awaited.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/mpbs_pkg.sv
src/mpbs_ram.sv
src/mpbs_out_fifo.sv
src/multi_pattern_byte_scanner_core.sv
tb/multi_pattern_byte_scanner_core_test.sv
